// ===== hdl/bba_pkg.sv =====
package bba_pkg;

    // Request and response codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_REGION_BASE = 2'd0;
    localparam logic [1:0] CFG_SPB_LOG2    = 2'd1;
    localparam logic [1:0] CFG_TOTAL       = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int SECTOR_W   = 32;
    localparam int SHIFT_W    = 3;
    localparam int TOTAL_W    = 11;

    // Reset values of the configuration registers
    localparam logic [SECTOR_W-1:0] RST_REGION_BASE = 32'd0;
    localparam logic [SHIFT_W-1:0]  RST_SPB_LOG2    = 3'd1;
    localparam logic [TOTAL_W-1:0]  RST_TOTAL       = 11'd1024;

    typedef struct packed {
        logic                opcode;
        logic [SECTOR_W-1:0] block_sector;
    } t_req;

    typedef struct packed {
        logic [1:0]          status;
        logic [SECTOR_W-1:0] result_sector;
        logic [TOTAL_W-1:0]  free_blocks;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

// ===== hdl/bba_cell.sv =====
// One word of the used-block map. On a shift the cell takes its neighbor's word.
module bba_cell #(
    parameter int SCAN_WORD = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  logic [SCAN_WORD-1:0] i_word,
    output logic [SCAN_WORD-1:0] o_word
);

    logic [SCAN_WORD-1:0] r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else if (i_shift) begin
            r_word <= i_word;
        end
    end

    assign o_word = r_word;

endmodule

// ===== hdl/block_bitmap_allocator.sv =====
// Channel | Direction | Handshake                 | Payload
// in      | input     | i_in_valid / o_in_stall   | i_in_data  (bba_pkg::t_req)
// out     | output    | o_out_valid / i_out_stall | o_out_data (bba_pkg::t_rsp)
// cfg     | input     | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// Each request passes through a setup state, a scan state in which the ring of
// cells rotates each map word in turn under the head logic, a result state, and
// then idle again to take the next. The response register lets the next request
// start while a response is stalled; only the result state waits for it.
// Synchronous reset clears the whole map.
module block_bitmap_allocator #(
    parameter int MAX_BLOCKS = 1024,
    parameter int SCAN_WORD  = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  bba_pkg::t_req                     i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output bba_pkg::t_rsp                     o_out_data,
    input  logic                              i_cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bba_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int NWORDS = MAX_BLOCKS / SCAN_WORD;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int OFF_W  = $clog2(SCAN_WORD);
    localparam logic [CNT_W-1:0] LAST_BASE = CNT_W'(MAX_BLOCKS - SCAN_WORD);
    localparam logic [CNT_W-1:0] WORD_CNT  = CNT_W'(SCAN_WORD);

    // Configuration registers
    logic [bba_pkg::SECTOR_W-1:0] r_base;
    logic [bba_pkg::SHIFT_W-1:0]  r_shift;
    logic [bba_pkg::TOTAL_W-1:0]  r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= bba_pkg::RST_REGION_BASE;
            r_shift <= bba_pkg::RST_SPB_LOG2;
            r_total <= bba_pkg::RST_TOTAL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bba_pkg::CFG_REGION_BASE: r_base  <= i_cfg_data;
                bba_pkg::CFG_SPB_LOG2:    r_shift <= i_cfg_data[bba_pkg::SHIFT_W-1:0];
                bba_pkg::CFG_TOTAL:       r_total <= i_cfg_data[bba_pkg::TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    bba_pkg::t_state r_state, n_state;

    logic                          r_op;
    logic [bba_pkg::SECTOR_W-1:0]  r_sector;
    logic [CNT_W-1:0]              r_eff;
    logic [CNT_W-1:0]              r_remain;
    logic [CNT_W-1:0]              r_word_base;
    logic [IDX_W-1:0]              r_idx;
    logic                          r_bad;
    logic                          r_found;
    logic                          r_freed;
    logic [CNT_W-1:0]              r_used;
    logic                          r_out_valid;
    bba_pkg::t_rsp                 r_out;

    logic in_xfer, out_free, scan_last, shift_en;

    assign in_xfer   = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign scan_last = (r_word_base == LAST_BASE);

    // Ring of map cells: cell 0 is the head, the head word returns at the tail
    logic [SCAN_WORD-1:0] w_word [NWORDS];
    logic [SCAN_WORD-1:0] head_mod;

    genvar gi;
    generate
        for (gi = 0; gi < NWORDS; gi++) begin : g_cell
            logic [SCAN_WORD-1:0] cell_in;
            if (gi == NWORDS - 1) begin : g_tail
                assign cell_in = head_mod;
            end else begin : g_mid
                assign cell_in = w_word[gi+1];
            end
            bba_cell #(.SCAN_WORD(SCAN_WORD)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_shift(shift_en),
                .i_word (cell_in),
                .o_word (w_word[gi])
            );
        end
    endgenerate

    // Head logic: first free bit on allocate, target bit on free
    logic [SCAN_WORD-1:0] cand, iso, sel;
    logic [OFF_W-1:0]     pos;
    logic                 any;
    logic [CNT_W-1:0]     local_off;
    logic                 hit, sel_set;

    always_comb begin
        for (int j = 0; j < SCAN_WORD; j++) begin
            cand[j] = !w_word[0][j] && (CNT_W'(j) < r_remain) && !r_found;
        end
        iso = cand & (~cand + 1'b1);
        any = |cand;
        pos = '0;
        for (int j = 0; j < SCAN_WORD; j++) begin
            if (iso[j]) begin
                pos = pos | OFF_W'(j);
            end
        end

        local_off = CNT_W'(r_idx) - r_word_base;
        hit = !r_bad && (CNT_W'(r_idx) >= r_word_base) && (local_off < WORD_CNT);
        for (int j = 0; j < SCAN_WORD; j++) begin
            sel[j] = hit && (local_off == CNT_W'(j));
        end
        sel_set = |(sel & w_word[0]);

        if (r_op == bba_pkg::OP_ALLOC) begin
            head_mod = w_word[0] | iso;
        end else begin
            head_mod = w_word[0] & ~sel;
        end
    end

    // Setup-cycle values
    logic [CNT_W-1:0]             eff_c;
    logic [bba_pkg::SECTOR_W-1:0] off_c, idxw_c;

    always_comb begin
        eff_c  = (32'(r_total) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(r_total);
        off_c  = r_sector - r_base;
        idxw_c = off_c >> r_shift;
    end

    // Result-cycle values
    logic [CNT_W-1:0]             used_c;
    logic [1:0]                   status_c;
    logic [bba_pkg::SECTOR_W-1:0] result_c;
    logic [CNT_W-1:0]             free_c;

    always_comb begin
        used_c   = r_used;
        status_c = bba_pkg::ST_OK;
        result_c = '0;
        if (r_op == bba_pkg::OP_ALLOC) begin
            if (r_found) begin
                used_c   = r_used + 1'b1;
                result_c = r_base + (32'(r_idx) << r_shift);
            end else begin
                status_c = bba_pkg::ST_FULL;
            end
        end else begin
            if (r_freed) begin
                if (r_used != '0) begin
                    used_c = r_used - 1'b1;
                end
            end else begin
                status_c = bba_pkg::ST_BAD;
            end
        end
        free_c = (r_eff > used_c) ? (r_eff - used_c) : '0;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bba_pkg::S_IDLE: if (in_xfer) n_state = bba_pkg::S_PREP;
            bba_pkg::S_PREP: n_state = bba_pkg::S_SCAN;
            bba_pkg::S_SCAN: if (scan_last) n_state = bba_pkg::S_DONE;
            bba_pkg::S_DONE: if (out_free) n_state = bba_pkg::S_IDLE;
            default:         n_state = bba_pkg::S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_stall = 1'b1;
        shift_en   = 1'b0;
        case (r_state)
            bba_pkg::S_IDLE: o_in_stall = 1'b0;
            bba_pkg::S_SCAN: shift_en   = 1'b1;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bba_pkg::S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_freed     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                bba_pkg::S_PREP: begin
                    r_found <= 1'b0;
                    r_freed <= 1'b0;
                end
                bba_pkg::S_SCAN: begin
                    if (r_op == bba_pkg::OP_ALLOC && any) begin
                        r_found <= 1'b1;
                    end
                    if (r_op == bba_pkg::OP_FREE && sel_set) begin
                        r_freed <= 1'b1;
                    end
                end
                bba_pkg::S_DONE: begin
                    if (out_free) begin
                        r_used      <= used_c;
                        r_out_valid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Request datapath registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op     <= i_in_data.opcode;
            r_sector <= i_in_data.block_sector;
        end
        case (r_state)
            bba_pkg::S_PREP: begin
                r_eff       <= eff_c;
                r_remain    <= eff_c;
                r_word_base <= '0;
                r_bad       <= (r_sector < r_base) || (idxw_c >= 32'(eff_c));
                r_idx       <= idxw_c[IDX_W-1:0];
            end
            bba_pkg::S_SCAN: begin
                r_word_base <= r_word_base + WORD_CNT;
                r_remain    <= (r_remain > WORD_CNT) ? (r_remain - WORD_CNT) : '0;
                if (r_op == bba_pkg::OP_ALLOC && any) begin
                    r_idx <= IDX_W'(r_word_base + CNT_W'(pos));
                end
            end
            bba_pkg::S_DONE: begin
                if (out_free) begin
                    r_out.status        <= status_c;
                    r_out.result_sector <= result_c;
                    r_out.free_blocks   <= bba_pkg::TOTAL_W'(free_c);
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/bba_checker.sv =====
// Port-level checks for the allocator
module bba_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input bba_pkg::t_rsp o_out_data
);

    // A stalled response stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("response dropped while stalled");

    // A request transfer makes the block busy for the scan
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a transfer");

    // Failed requests carry no sector
    a_zero_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != bba_pkg::ST_OK |-> o_out_data.result_sector == '0)
        else $error("sector returned on a failed request");

    // Full means no free block is left
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == bba_pkg::ST_FULL |-> o_out_data.free_blocks == '0)
        else $error("full status with free blocks left");

endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);
